// File: hdl/latency_pacing_deadline_table_macros.svh
// Assertion macros for the latency pacing deadline table.
// Used by ldt_ctrl, which checks its own logic; expects clk and rst_n in scope.
`ifndef LATENCY_PACING_DEADLINE_TABLE_MACROS_SVH
`define LATENCY_PACING_DEADLINE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ldt_pkg.sv
// Package for the latency pacing deadline table: request types, codes and states.
// No dependencies.
`timescale 1ns / 1ps
package ldt_pkg;

  localparam int TIME_W        = 48;
  localparam int SLOTS_DEFAULT = 32;

  localparam logic [TIME_W-1:0] TARGET_RESET = 48'd1000;
  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

  localparam logic       MODE_COMPLETE = 1'b0;
  localparam logic       MODE_POLL     = 1'b1;

  localparam logic [1:0] KIND_RELEASE   = 2'd0;
  localparam logic [1:0] KIND_ARMED     = 2'd1;
  localparam logic [1:0] KIND_POLL_DONE = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [4:0]        slot;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] now_time;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [4:0]        slot_out;
    logic [TIME_W-1:0] timeout;
    logic              timeout_valid;
    logic              last;
  } out_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_C1,
    S_C2,
    S_C3,
    S_C4,
    S_C5,
    S_C6,
    S_P0,
    S_P_RD,
    S_P_CMP,
    S_P_UPD,
    S_P_FIN
  } ldt_state_t;

endpackage

// File: hdl/ldt_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Generic; holds the per-slot deadline or slack words.
`timescale 1ns / 1ps
module ldt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ldt_ctrl.sv
// Sequencer and datapath of the latency pacing deadline table.
// Depends on ldt_pkg and the assertion macros; drives the deadline and slack RAMs.
`timescale 1ns / 1ps
`include "latency_pacing_deadline_table_macros.svh"
module ldt_ctrl
  import ldt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output out_req_t          out_req,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  output logic [AW-1:0]     mem_waddr,
  output logic              dl_we,
  output logic [TIME_W-1:0] dl_wdata,
  input  logic [TIME_W-1:0] dl_rdata,
  output logic              sl_we,
  output logic [TIME_W-1:0] sl_wdata,
  input  logic [TIME_W-1:0] sl_rdata
);

  localparam int IW = $clog2(SLOTS + 1);

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  ldt_state_t        state_r, state_nxt;
  logic [TIME_W-1:0] target_r;
  in_req_t           req_r;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              ev_r, ev_nxt;
  logic [TIME_W-1:0] ed_r, ed_nxt;
  logic [SLOTS-1:0]  armed_r, armed_nxt;
  logic [SLOTS-1:0]  svld_r, svld_nxt;
  logic              out_valid_r;
  out_req_t          out_req_r, out_nxt;
  logic              load_out;

  logic              rvld_r;
  logic [TIME_W-1:0] elapsed_r;
  logic              ge_r;
  logic [TIME_W-1:0] a_r;
  logic [TIME_W-1:0] new_slack_r;
  logic [TIME_W-1:0] rem2_r;
  logic              arm_r;
  logic [TIME_W-1:0] dl_r;
  logic              exp_r;
  logic [TIME_W-1:0] lat_r;

  logic              out_free;
  logic [AW-1:0]     slot_addr;
  logic [AW-1:0]     idx_addr;
  logic [TIME_W-1:0] slack_eff;
  logic [TIME_W:0]   ed_diff;
  logic              ed_after;
  logic [TIME_W-1:0] to_earliest;
  logic              in_range;
  logic [TIME_W:0]   d_el;
  logic [TIME_W:0]   d_rem;
  logic [TIME_W:0]   d_lat;

  assign out_free    = !out_valid_r || out_ready;
  assign slot_addr   = AW'(req_r.slot);
  assign idx_addr    = idx_r[AW-1:0];
  assign slack_eff   = rvld_r ? sl_rdata : '0;
  assign ed_diff     = {1'b0, ed_r} - {1'b0, req_r.now_time};
  assign ed_after    = !ed_diff[TIME_W] && (ed_diff[TIME_W-1:0] != '0);
  assign to_earliest = (ev_r && ed_after) ? ed_diff[TIME_W-1:0] : '0;
  assign in_range    = ({27'd0, in_req.slot} < 32'(SLOTS));
  assign d_el        = {1'b0, elapsed_r} - {1'b0, target_r};
  assign d_rem       = {1'b0, a_r} - {1'b0, slack_eff};
  assign d_lat       = {1'b0, req_r.now_time} - {1'b0, dl_rdata};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;
  assign dl_wdata  = dl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      target_r    <= TARGET_RESET;
      idx_r       <= '0;
      ev_r        <= 1'b0;
      ed_r        <= TIME_MAX;
      armed_r     <= '0;
      svld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ev_r     <= ev_nxt;
      ed_r     <= ed_nxt;
      armed_r  <= armed_nxt;
      svld_r   <= svld_nxt;
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ev_nxt    = ev_r;
    ed_nxt    = ed_r;
    armed_nxt = armed_r;
    svld_nxt  = svld_r;
    load_out  = 1'b0;
    out_nxt   = out_req_r;
    mem_re    = 1'b0;
    mem_raddr = idx_addr;
    mem_waddr = slot_addr;
    dl_we     = 1'b0;
    sl_we     = 1'b0;
    sl_wdata  = new_slack_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req.mode == MODE_POLL) begin
            state_nxt = S_P0;
          end else if (in_range) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(in_req.slot);
            state_nxt = S_C1;
          end
        end
      end
      S_C1: state_nxt = S_C2;
      S_C2: state_nxt = S_C3;
      S_C3: state_nxt = S_C4;
      S_C4: state_nxt = S_C5;
      S_C5: begin
        sl_we              = 1'b1;
        svld_nxt[slot_addr] = 1'b1;
        armed_nxt[slot_addr] = arm_r;
        if (arm_r) begin
          dl_we = 1'b1;
          if (!ev_r || dl_r < ed_r) begin
            ed_nxt = dl_r;
            ev_nxt = 1'b1;
          end
        end
        state_nxt = S_C6;
      end
      S_C6: begin
        if (out_free) begin
          load_out = 1'b1;
          out_nxt  = '{kind: arm_r ? KIND_ARMED : KIND_RELEASE, slot_out: req_r.slot,
                       timeout: to_earliest, timeout_valid: ev_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_P0: begin
        if (!ev_r || ed_after) begin
          if (out_free) begin
            load_out = 1'b1;
            out_nxt  = '{kind: KIND_POLL_DONE, slot_out: 5'd0, timeout: to_earliest,
                         timeout_valid: ev_r, last: 1'b1};
            state_nxt = S_IDLE;
          end
        end else begin
          ed_nxt    = TIME_MAX;
          ev_nxt    = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        if (idx_r == IW'(SLOTS)) begin
          state_nxt = S_P_FIN;
        end else if (armed_r[idx_addr]) begin
          mem_re    = 1'b1;
          state_nxt = S_P_CMP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_P_CMP: state_nxt = S_P_UPD;
      S_P_UPD: begin
        mem_waddr = idx_addr;
        if (exp_r) begin
          if (out_free) begin
            sl_we               = 1'b1;
            sl_wdata            = sat_add(slack_eff, lat_r);
            svld_nxt[idx_addr]  = 1'b1;
            armed_nxt[idx_addr] = 1'b0;
            load_out            = 1'b1;
            out_nxt = '{kind: KIND_RELEASE, slot_out: 5'(idx_r), timeout: '0,
                        timeout_valid: 1'b0, last: 1'b0};
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_P_RD;
          end
        end else begin
          if (!ev_r || dl_rdata < ed_r) begin
            ed_nxt = dl_rdata;
            ev_nxt = 1'b1;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P_RD;
        end
      end
      S_P_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          out_nxt  = '{kind: KIND_POLL_DONE, slot_out: 5'd0, timeout: to_earliest,
                       timeout_valid: ev_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_req;
    end
    if (mem_re) begin
      rvld_r <= svld_r[mem_raddr];
    end
    if (load_out) begin
      out_req_r <= out_nxt;
    end
    unique case (state_r)
      S_C1: elapsed_r <= req_r.now_time - req_r.start_time;
      S_C2: begin
        ge_r <= !d_el[TIME_W];
        a_r  <= d_el[TIME_W] ? (target_r - elapsed_r) : d_el[TIME_W-1:0];
      end
      S_C3: begin
        rem2_r <= d_rem[TIME_W-1:0];
        if (ge_r) begin
          new_slack_r <= sat_add(slack_eff, a_r);
          arm_r       <= 1'b0;
        end else if (!d_rem[TIME_W]) begin
          new_slack_r <= '0;
          arm_r       <= 1'b1;
        end else begin
          new_slack_r <= slack_eff - a_r;
          arm_r       <= 1'b0;
        end
      end
      S_C4: dl_r <= sat_add(req_r.now_time, rem2_r);
      S_P_CMP: begin
        exp_r <= !d_lat[TIME_W];
        lat_r <= d_lat[TIME_W-1:0];
      end
      default: begin
      end
    endcase
  end

  `LDT_ASSERT_IMP(a_scan_reads_armed, mem_re && state_r == S_P_RD, armed_r[idx_addr], "scan read of an idle slot")
  `LDT_ASSERT_IMP(a_no_rw_overlap, dl_we || sl_we, !mem_re, "RAM read and write in one cycle")
  `LDT_ASSERT_NXT(a_last_ends_item, load_out && out_nxt.last, state_r == S_IDLE, "final result without return to idle")
  `LDT_ASSERT_NXT(a_arm_sets_earliest, state_r == S_C5 && arm_r, ev_r, "armed deadline not tracked")

endmodule

// File: hdl/latency_pacing_deadline_table.sv
// A completion reads its slot's slack and steps through S_C1 to S_C6 before its result.
// A poll with no expired deadline answers from S_P0; a scanning poll visits every slot
// in turn; it reads armed slots and writes back expired ones (S_P_RD, S_P_CMP, S_P_UPD).
// One request is worked on at a time; the next is accepted while a result waits.
// Synchronous active-low reset clears the slot flags, slack valid bits and the
// earliest deadline; target_r returns to TARGET_RESET. No clearing pass is needed.
`timescale 1ns / 1ps
module latency_pacing_deadline_table
  import ldt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output out_req_t          out_req,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [AW-1:0]     mem_waddr;
  logic              dl_we;
  logic [TIME_W-1:0] dl_wdata;
  logic [TIME_W-1:0] dl_rdata;
  logic              sl_we;
  logic [TIME_W-1:0] sl_wdata;
  logic [TIME_W-1:0] sl_rdata;

  ldt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS), .AW(AW)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (mem_waddr),
    .wdata (dl_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (dl_rdata)
  );

  ldt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS), .AW(AW)) u_sl_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (mem_waddr),
    .wdata (sl_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (sl_rdata)
  );

  ldt_ctrl #(.SLOTS(SLOTS), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_waddr (mem_waddr),
    .dl_we     (dl_we),
    .dl_wdata  (dl_wdata),
    .dl_rdata  (dl_rdata),
    .sl_we     (sl_we),
    .sl_wdata  (sl_wdata),
    .sl_rdata  (sl_rdata)
  );

endmodule

// File: tb/sv/latency_pacing_deadline_table_tb.sv
// Self-checking testbench for the latency pacing deadline table: directed and random requests.
// It predicts every result from a shadow copy of the slot table and checks each field.
// Depends on ldt_pkg and latency_pacing_deadline_table.
`timescale 1ns / 1ps
module latency_pacing_deadline_table_tb
  import ldt_pkg::*;
();

  localparam int NSLOT = SLOTS_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 120;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_req_t           in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_req_t          out_req;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;

  logic [TIME_W-1:0] sh_deadline [NSLOT];
  logic              sh_armed [NSLOT];
  logic [TIME_W-1:0] sh_slack [NSLOT];
  logic [TIME_W-1:0] sh_earliest;
  logic              sh_earliest_vld;
  logic [TIME_W-1:0] sh_target;

  out_req_t          pending_out [$];
  logic [TIME_W-1:0] sim_now;
  bit                idle_on = 1'b0;
  bit                stall_on = 1'b0;
  int                errors = 0;
  int unsigned       cycle_count = 0;

  latency_pacing_deadline_table #(.SLOTS(NSLOT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_req  (out_req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] time_left(logic [TIME_W-1:0] now);
    if (!sh_earliest_vld || sh_earliest <= now) return '0;
    return sh_earliest - now;
  endfunction

  function automatic out_req_t make_out(logic [1:0] kind, logic [4:0] slot,
                                        logic [TIME_W-1:0] tmo, logic tv, logic fin);
    out_req_t o;
    o.kind = kind;
    o.slot_out = slot;
    o.timeout = tmo;
    o.timeout_valid = tv;
    o.last = fin;
    return o;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NSLOT; i++) begin
      sh_deadline[i] = '0;
      sh_armed[i] = 1'b0;
      sh_slack[i] = '0;
    end
    sh_earliest = TIME_MAX;
    sh_earliest_vld = 1'b0;
    sh_target = TARGET_RESET;
  endfunction

  function automatic void shadow_step(in_req_t r);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] dl;
    logic [1:0]        kind;
    if (r.mode == MODE_COMPLETE) begin
      elapsed = r.now_time - r.start_time;
      if (elapsed >= sh_target) begin
        sh_slack[r.slot] = sat_add(sh_slack[r.slot], elapsed - sh_target);
        sh_armed[r.slot] = 1'b0;
        kind = KIND_RELEASE;
      end else begin
        rem = sh_target - elapsed;
        if (rem >= sh_slack[r.slot]) begin
          dl = sat_add(r.now_time, rem - sh_slack[r.slot]);
          sh_slack[r.slot] = '0;
          sh_deadline[r.slot] = dl;
          sh_armed[r.slot] = 1'b1;
          if (!sh_earliest_vld || dl < sh_earliest) begin
            sh_earliest = dl;
            sh_earliest_vld = 1'b1;
          end
          kind = KIND_ARMED;
        end else begin
          sh_slack[r.slot] = sh_slack[r.slot] - rem;
          sh_armed[r.slot] = 1'b0;
          kind = KIND_RELEASE;
        end
      end
      pending_out.push_back(make_out(kind, r.slot, time_left(r.now_time), sh_earliest_vld, 1'b1));
    end else if (!sh_earliest_vld) begin
      pending_out.push_back(make_out(KIND_POLL_DONE, '0, '0, 1'b0, 1'b1));
    end else if (sh_earliest > r.now_time) begin
      pending_out.push_back(make_out(KIND_POLL_DONE, '0, sh_earliest - r.now_time, 1'b1, 1'b1));
    end else begin
      sh_earliest = TIME_MAX;
      sh_earliest_vld = 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        if (sh_armed[i]) begin
          if (r.now_time >= sh_deadline[i]) begin
            sh_slack[i] = sat_add(sh_slack[i], r.now_time - sh_deadline[i]);
            sh_armed[i] = 1'b0;
            pending_out.push_back(make_out(KIND_RELEASE, 5'(i), '0, 1'b0, 1'b0));
          end else if (!sh_earliest_vld || sh_deadline[i] < sh_earliest) begin
            sh_earliest = sh_deadline[i];
            sh_earliest_vld = 1'b1;
          end
        end
      end
      pending_out.push_back(make_out(KIND_POLL_DONE, '0, time_left(r.now_time),
                                     sh_earliest_vld, 1'b1));
    end
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] exp_v,
                                      logic [TIME_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_req_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_req);
        errors++;
      end else begin
        exp_r = pending_out.pop_front();
        check_field("kind", TIME_W'(exp_r.kind), TIME_W'(out_req.kind));
        check_field("slot_out", TIME_W'(exp_r.slot_out), TIME_W'(out_req.slot_out));
        check_field("timeout", exp_r.timeout, out_req.timeout);
        check_field("timeout_valid", TIME_W'(exp_r.timeout_valid),
                    TIME_W'(out_req.timeout_valid));
        check_field("last", TIME_W'(exp_r.last), TIME_W'(out_req.last));
      end
    end
  end

  initial begin : result_sink
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] frac_of(logic [TIME_W-1:0] v, int unsigned pct);
    logic [63:0] p;
    p = 64'(v) * 64'(pct) / 64'd100;
    return p[TIME_W-1:0];
  endfunction

  task automatic send_req(in_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow_step(r);
  endtask

  task automatic send_completion(logic [4:0] slot, logic [TIME_W-1:0] start,
                                 logic [TIME_W-1:0] now);
    in_req_t r;
    r.mode = MODE_COMPLETE;
    r.slot = slot;
    r.start_time = start;
    r.now_time = now;
    send_req(r);
  endtask

  task automatic send_poll(logic [TIME_W-1:0] now);
    in_req_t r;
    r.mode = MODE_POLL;
    r.slot = '0;
    r.start_time = '0;
    r.now_time = now;
    send_req(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_target(logic [TIME_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_target = v;
  endtask

  task automatic next_item(output in_req_t r);
    int unsigned pick;
    logic [TIME_W-1:0] elapsed;
    pick = $urandom_range(0, 15);
    r.mode = MODE_POLL;
    r.slot = 5'($urandom);
    r.start_time = rand48();
    r.now_time = rand48();
    if (pick == 0) begin
      r.mode = 1'($urandom);
    end else if (pick < 5) begin
      sim_now = sim_now + frac_of(sh_target, $urandom_range(0, 150))
                + TIME_W'($urandom_range(0, 2));
      r.now_time = sim_now;
    end else begin
      sim_now = sim_now + frac_of(sh_target, $urandom_range(0, 20));
      elapsed = frac_of(sh_target, $urandom_range(0, 200)) + TIME_W'($urandom_range(0, 1));
      r.mode = MODE_COMPLETE;
      r.start_time = sim_now - elapsed;
      r.now_time = sim_now;
    end
  endtask

  task automatic test_empty_poll();
    send_poll(48'd0);
  endtask

  task automatic test_completion_paths();
    send_completion(5'd0, 48'd0, 48'd500);
    send_completion(5'd1, 48'd100, 48'd1100);
    send_completion(5'd2, 48'd0, 48'd1300);
    send_completion(5'd2, 48'd1000, 48'd1500);
    send_completion(5'd3, 48'd0, 48'd5000);
    send_completion(5'd3, 48'd4800, 48'd5000);
    send_completion(5'd4, TIME_MAX - 48'd99, 48'd100);
    send_completion(5'd5, TIME_MAX - 48'd10, TIME_MAX - 48'd5);
    send_completion(5'd6, 48'd0, 48'd1250);
    send_completion(5'd6, 48'd1000, 48'd1750);
  endtask

  task automatic test_poll_scan();
    send_poll(48'd800);
    send_completion(5'd4, 48'd0, 48'd2000);
    send_poll(48'd850);
    send_poll(48'd1750);
    send_completion(5'd7, 48'd0, 48'd500);
    send_poll(TIME_MAX);
    send_completion(5'd7, 48'd0, TIME_MAX);
    send_completion(5'd7, 48'd100, 48'd200);
  endtask

  task automatic test_target_extremes();
    set_target('0);
    send_completion(5'd8, 48'd5, 48'd5);
    send_completion(5'd9, TIME_MAX, 48'd0);
    set_target(TIME_MAX);
    send_completion(5'd10, 48'd990, 48'd1000);
    send_completion(5'd11, 48'd1, 48'd0);
    send_poll(48'd0);
    send_poll(TIME_MAX);
  endtask

  task automatic test_random_traffic();
    in_req_t r;
    logic [TIME_W-1:0] tgt;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: tgt = TIME_W'($urandom_range(1, 4000));
        1: tgt = rand48();
        2: tgt = TIME_W'($urandom_range(50, 500));
        default: tgt = TIME_W'($urandom_range(500, 3000));
      endcase
      set_target(tgt);
      idle_on = (ph < 3) && ($urandom_range(0, 3) != 0);
      stall_on = (ph < 3) && ($urandom_range(0, 3) != 0);
      sim_now = (ph == 1) ? rand48() : 48'($urandom);
      if (ph == 2) begin
        for (int s = 0; s < NSLOT; s++) send_completion(5'(s), sim_now, sim_now);
        sim_now = sim_now + tgt + 48'd1;
        send_poll(sim_now);
      end
      for (int k = 0; k < ((ph == 2) ? 12 : 45); k++) begin
        next_item(r);
        send_req(r);
        if (ph == 0 && k == 20) drain_results();
      end
    end
  endtask

  initial begin
    shadow_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;
    stall_on = 1'b1;
    test_empty_poll();
    test_completion_paths();
    test_poll_scan();
    test_target_extremes();
    test_random_traffic();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
